FILE: rtl/toroidal_life_generation_macros.svh
// Assertion macros for the toroidal life generation back end
`ifndef TOROIDAL_LIFE_GENERATION_MACROS_SVH
`define TOROIDAL_LIFE_GENERATION_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define TLG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define TLG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tlg_pkg.sv
// Types and constants shared by the toroidal life generation block
`default_nettype none

package tlg_pkg;

    localparam int MAX_WIDTH    = 64;
    localparam int MAX_HEIGHT   = 4096;
    localparam int WIDTH_CFG_W  = 7;
    localparam int HEIGHT_CFG_W = 13;
    localparam int ROW_IDX_W    = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;

    localparam int WIDTH_RESET  = 32;
    localparam int HEIGHT_RESET = 32;
    localparam int MIN_HEIGHT   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    // Role of a row within its generation
    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_SECOND,
        KIND_MIDDLE,
        KIND_LAST
    } t_row_kind;

    // Which of the three results of the last row is being produced
    typedef enum logic [1:0] {
        BK_NEAR,
        BK_WRAP,
        BK_TOP
    } t_back_state;

    typedef struct packed {
        logic [MAX_WIDTH-1:0]   cells;
        logic [ROW_IDX_W-1:0]   row;
        logic [WIDTH_CFG_W-1:0] width;
        t_row_kind              kind;
    } t_row_job;

endpackage

`default_nettype wire

FILE: rtl/tlg_front.sv
// Front end: config registers, input beat masking and row classification
`default_nettype none

module tlg_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wr_en,
    input  wire [tlg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [tlg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                            i_in_valid,
    input  wire [tlg_pkg::MAX_WIDTH-1:0]   i_row_cells,
    input  wire                            i_queue_full,
    output logic                           o_in_stall,
    output logic                           o_push,
    output tlg_pkg::t_row_job              o_job
);
    import tlg_pkg::*;

    logic [WIDTH_CFG_W-1:0]  r_grid_width;
    logic [HEIGHT_CFG_W-1:0] r_grid_height;
    logic [ROW_IDX_W-1:0]    r_rows_seen;
    logic [ROW_IDX_W-1:0]    n_rows_seen;

    logic [WIDTH_CFG_W-1:0]  eff_width;
    logic [HEIGHT_CFG_W-1:0] eff_height;
    logic [MAX_WIDTH-1:0]    width_mask;
    logic                    is_last;
    t_row_kind               kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= WIDTH_CFG_W'(WIDTH_RESET);
            r_grid_height <= HEIGHT_CFG_W'(HEIGHT_RESET);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[WIDTH_CFG_W-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[HEIGHT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_grid_width == '0) begin
            eff_width = WIDTH_CFG_W'(1);
        end else if (r_grid_width > WIDTH_CFG_W'(MAX_WIDTH)) begin
            eff_width = WIDTH_CFG_W'(MAX_WIDTH);
        end else begin
            eff_width = r_grid_width;
        end

        if (r_grid_height < HEIGHT_CFG_W'(MIN_HEIGHT)) begin
            eff_height = HEIGHT_CFG_W'(MIN_HEIGHT);
        end else if (r_grid_height > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
            eff_height = HEIGHT_CFG_W'(MAX_HEIGHT);
        end else begin
            eff_height = r_grid_height;
        end

        for (int i = 0; i < MAX_WIDTH; i++) begin
            width_mask[i] = (WIDTH_CFG_W'(i) < eff_width);
        end
    end

    // A lowered height makes any later row the last one
    assign is_last = (r_rows_seen >= ROW_IDX_W'(2)) &&
                     ({1'b0, r_rows_seen} >= (eff_height - HEIGHT_CFG_W'(1)));

    always_comb begin
        if (r_rows_seen == '0) begin
            kind = KIND_FIRST;
        end else if (r_rows_seen == ROW_IDX_W'(1)) begin
            kind = KIND_SECOND;
        end else if (is_last) begin
            kind = KIND_LAST;
        end else begin
            kind = KIND_MIDDLE;
        end
        n_rows_seen = is_last ? '0 : r_rows_seen + ROW_IDX_W'(1);
    end

    assign o_in_stall  = i_queue_full;
    assign o_push      = i_in_valid && !i_queue_full;
    assign o_job.cells = i_row_cells & width_mask;
    assign o_job.row   = r_rows_seen;
    assign o_job.width = eff_width;
    assign o_job.kind  = kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_seen <= '0;
        end else if (o_push) begin
            r_rows_seen <= n_rows_seen;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tlg_queue.sv
// Short job queue between front and back
`default_nettype none

module tlg_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  tlg_pkg::t_row_job   i_job,
    input  wire                 i_pop,
    output logic                o_full,
    output logic                o_valid,
    output tlg_pkg::t_row_job   o_job
);
    import tlg_pkg::*;

    t_row_job              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic                  do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tlg_back.sv
// Back end: row window, per-cell neighbor count and output register
`default_nettype none
`include "toroidal_life_generation_macros.svh"

module tlg_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_job_valid,
    input  tlg_pkg::t_row_job                  i_job,
    output logic                               o_pop,
    input  wire                                i_out_stall,
    output logic                               o_out_valid,
    output logic [tlg_pkg::ROW_IDX_W-1:0]      o_row_index,
    output logic [tlg_pkg::MAX_WIDTH-1:0]      o_next_cells,
    output logic                               o_last_of_run
);
    import tlg_pkg::*;

    function automatic logic [MAX_WIDTH-1:0] next_gen(
        input logic [MAX_WIDTH-1:0]   above,
        input logic [MAX_WIDTH-1:0]   mid,
        input logic [MAX_WIDTH-1:0]   below,
        input logic [WIDTH_CFG_W-1:0] w
    );
        logic [MAX_WIDTH-1:0] res;
        logic [MAX_WIDTH-1:0] west_a;
        logic [MAX_WIDTH-1:0] east_a;
        logic [MAX_WIDTH-1:0] west_m;
        logic [MAX_WIDTH-1:0] east_m;
        logic [MAX_WIDTH-1:0] west_b;
        logic [MAX_WIDTH-1:0] east_b;
        logic [5:0]           wm1;
        logic [3:0]           n;
        res = '0;
        wm1 = 6'(w - WIDTH_CFG_W'(1));
        // columns wrap at the width in use; at width 1 or 2 west and east coincide.
        // A row kept from a wider setting folds its upper bits in through the wrap shift.
        west_a = (above << 1) | (above >> wm1);
        east_a = (above >> 1) | (MAX_WIDTH'(above[0]) << wm1);
        west_m = (mid << 1) | (mid >> wm1);
        east_m = (mid >> 1) | (MAX_WIDTH'(mid[0]) << wm1);
        west_b = (below << 1) | (below >> wm1);
        east_b = (below >> 1) | (MAX_WIDTH'(below[0]) << wm1);
        for (int i = 0; i < MAX_WIDTH; i++) begin
            n  = 4'(west_a[i]) + 4'(above[i]) + 4'(east_a[i]) +
                 4'(west_m[i]) + 4'(east_m[i]) +
                 4'(west_b[i]) + 4'(below[i]) + 4'(east_b[i]);
            res[i] = (WIDTH_CFG_W'(i) < w) &&
                     ((n == 4'd3) || ((n == 4'd2) && mid[i]));
        end
        return res;
    endfunction

    t_back_state             r_state;
    t_back_state             n_state;
    logic [MAX_WIDTH-1:0]    r_first;
    logic [MAX_WIDTH-1:0]    r_second;
    logic [MAX_WIDTH-1:0]    r_older;
    logic [MAX_WIDTH-1:0]    r_newer;

    logic                    r_out_valid;
    logic [ROW_IDX_W-1:0]    r_out_row;
    logic [MAX_WIDTH-1:0]    r_out_cells;
    logic                    r_out_last;

    logic                    out_free;
    logic                    load;
    logic [MAX_WIDTH-1:0]    op_above;
    logic [MAX_WIDTH-1:0]    op_mid;
    logic [MAX_WIDTH-1:0]    op_below;
    logic [ROW_IDX_W-1:0]    res_row;
    logic                    res_last;
    logic [MAX_WIDTH-1:0]    res_cells;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load     = 1'b0;
        op_above = r_older;
        op_mid   = r_newer;
        op_below = i_job.cells;
        res_row  = i_job.row - ROW_IDX_W'(1);
        res_last = 1'b1;
        if (i_job_valid) begin
            case (i_job.kind)
                KIND_FIRST, KIND_SECOND: begin
                    o_pop = 1'b1;
                end
                KIND_MIDDLE: begin
                    load  = out_free;
                    o_pop = out_free;
                end
                KIND_LAST: begin
                    load = out_free;
                    case (r_state)
                        BK_NEAR: begin
                            res_last = 1'b0;
                            if (out_free) begin
                                n_state = BK_WRAP;
                            end
                        end
                        BK_WRAP: begin
                            op_above = r_newer;
                            op_mid   = i_job.cells;
                            op_below = r_first;
                            res_row  = i_job.row;
                            res_last = 1'b0;
                            if (out_free) begin
                                n_state = BK_TOP;
                            end
                        end
                        BK_TOP: begin
                            op_above = i_job.cells;
                            op_mid   = r_first;
                            op_below = r_second;
                            res_row  = '0;
                            o_pop    = out_free;
                            if (out_free) begin
                                n_state = BK_NEAR;
                            end
                        end
                        default: begin
                            n_state = BK_NEAR;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign res_cells = next_gen(op_above, op_mid, op_below, i_job.width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_NEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Row window moves once per job, as its last result, if any, is loaded
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_older <= r_newer;
            r_newer <= i_job.cells;
            if (i_job.kind == KIND_FIRST) begin
                r_first <= i_job.cells;
            end
            if (i_job.kind == KIND_SECOND) begin
                r_second <= i_job.cells;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_row   <= res_row;
            r_out_cells <= res_cells;
            r_out_last  <= res_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_index   = r_out_row;
    assign o_next_cells  = r_out_cells;
    assign o_last_of_run = r_out_last;

    `TLG_ASSERT_SAME(a_last_pop_at_top, o_pop && (i_job.kind == KIND_LAST), r_state == BK_TOP, "last row popped before its third result")
    `TLG_ASSERT_SAME(a_wrap_holds_last, r_state != BK_NEAR, i_job_valid && (i_job.kind == KIND_LAST), "wrap sequence without a last row at the head")
    `TLG_ASSERT_NEXT(a_top_result_row0, load && (r_state == BK_TOP), r_out_valid && (r_out_row == '0) && r_out_last, "top wrap result is not row 0 with last set")

endmodule

`default_nettype wire

FILE: rtl/toroidal_life_generation.sv
// Top level: one toroidal Life generation, streamed a row at a time
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_row_cells
//  out     | output    | o_out_valid / i_out_stall | o_row_index, o_next_cells, o_last_of_run
//  cfg     | input     | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// One row beat per cycle while o_in_stall is low; a middle row's result is registered in the
// output register after the job queue. The last row of a generation gives three results;
// the back end's single neighbor-count unit sets that, and a four-entry job queue absorbs it.
// Synchronous active-low reset; width and height come out of reset at 32.
// o_in_stall rises only when the job queue is full; i_out_stall backs up through the queue.
`default_nettype none

module toroidal_life_generation (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire [tlg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [tlg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire [tlg_pkg::MAX_WIDTH-1:0]       i_row_cells,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [tlg_pkg::ROW_IDX_W-1:0]      o_row_index,
    output logic [tlg_pkg::MAX_WIDTH-1:0]      o_next_cells,
    output logic                               o_last_of_run
);
    import tlg_pkg::*;

    logic     push;
    logic     pop;
    logic     queue_full;
    logic     head_valid;
    t_row_job push_job;
    t_row_job head_job;

    tlg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_row_cells  (i_row_cells),
        .i_queue_full (queue_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_job        (push_job)
    );

    tlg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    tlg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (head_valid),
        .i_job         (head_job),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_row_index   (o_row_index),
        .o_next_cells  (o_next_cells),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

FILE: tb/sv/toroidal_life_generation_tb.sv
// Self-checking testbench for the streamed toroidal Life generation block
`timescale 1ns / 1ps

module toroidal_life_generation_tb;
    import tlg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;   // index with no register behind it
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ROWS   = 350;

    typedef struct {
        logic [ROW_IDX_W-1:0] row_index;
        logic [MAX_WIDTH-1:0] cells;
        logic                 last;
    } t_life_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [MAX_WIDTH-1:0]  i_row_cells = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [ROW_IDX_W-1:0]  o_row_index;
    logic [MAX_WIDTH-1:0]  o_next_cells;
    logic                  o_last_of_run;

    toroidal_life_generation u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_row_cells   (i_row_cells),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_row_index   (o_row_index),
        .o_next_cells  (o_next_cells),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // shadow registers and predictor state
    logic [WIDTH_CFG_W-1:0]  cfg_width = WIDTH_CFG_W'(WIDTH_RESET);
    logic [HEIGHT_CFG_W-1:0] cfg_height = HEIGHT_CFG_W'(HEIGHT_RESET);
    logic [MAX_WIDTH-1:0]    row0_q = '0;
    logic [MAX_WIDTH-1:0]    row1_q = '0;
    logic [MAX_WIDTH-1:0]    older_q = '0;
    logic [MAX_WIDTH-1:0]    newer_q = '0;
    int unsigned             rows_seen_q = 0;

    logic [MAX_WIDTH-1:0] rows_to_send[$];
    t_life_row            next_gen_rows[$];
    int unsigned          mismatches = 0;

    function automatic int unsigned active_width();
        int unsigned w;
        w = cfg_width;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = cfg_height;
        if (h < MIN_HEIGHT) h = MIN_HEIGHT;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic logic [MAX_WIDTH-1:0] cell_mask(input int unsigned w);
        return (w >= MAX_WIDTH) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    // bit i takes column i-1, wrapping
    function automatic logic [MAX_WIDTH-1:0] shift_from_west(input logic [MAX_WIDTH-1:0] x,
                                                             input int unsigned w);
        return ((x << 1) | (x >> (w - 1))) & cell_mask(w);
    endfunction

    // bit i takes column i+1, wrapping
    function automatic logic [MAX_WIDTH-1:0] shift_from_east(input logic [MAX_WIDTH-1:0] x,
                                                             input int unsigned w);
        return ((x >> 1) | ((x & 64'd1) << (w - 1))) & cell_mask(w);
    endfunction

    function automatic logic [MAX_WIDTH-1:0] life_row(input logic [MAX_WIDTH-1:0] above,
                                                      input logic [MAX_WIDTH-1:0] mid,
                                                      input logic [MAX_WIDTH-1:0] below,
                                                      input int unsigned w);
        logic [MAX_WIDTH-1:0] nb [8];
        logic [MAX_WIDTH-1:0] res;
        int unsigned          cnt;
        nb[0] = shift_from_west(above, w);
        nb[1] = above;
        nb[2] = shift_from_east(above, w);
        nb[3] = shift_from_west(mid, w);
        nb[4] = shift_from_east(mid, w);
        nb[5] = shift_from_west(below, w);
        nb[6] = below;
        nb[7] = shift_from_east(below, w);
        res = '0;
        for (int i = 0; i < w; i++) begin
            cnt = 0;
            for (int k = 0; k < 8; k++) cnt += nb[k][i];
            if (cnt == BIRTH_COUNT || (cnt == SURVIVE_COUNT && mid[i])) res[i] = 1'b1;
        end
        return res;
    endfunction

    function automatic void push_result(input int unsigned row, input logic [MAX_WIDTH-1:0] cells,
                                        input logic last);
        t_life_row e;
        e.row_index = ROW_IDX_W'(row);
        e.cells     = cells;
        e.last      = last;
        next_gen_rows.push_back(e);
    endfunction

    // one accepted row beat -> the next-generation rows it completes
    function automatic void advance_life_row(input logic [MAX_WIDTH-1:0] cells);
        int unsigned          w;
        int unsigned          h;
        int unsigned          r;
        logic [MAX_WIDTH-1:0] cur;
        w   = active_width();
        h   = active_height();
        cur = cells & cell_mask(w);
        r   = rows_seen_q;
        if (r == 0) begin
            row0_q = cur;
        end else if (r == 1) begin
            row1_q = cur;
        end else begin
            push_result(r - 1, life_row(older_q, newer_q, cur, w), r < h - 1);
            // last row of the generation also closes the wrap rows
            if (r >= h - 1) begin
                push_result(r, life_row(newer_q, cur, row0_q, w), 1'b0);
                push_result(0, life_row(cur, row0_q, row1_q, w), 1'b1);
            end
        end
        older_q     = newer_q;
        newer_q     = cur;
        rows_seen_q = (r >= 2 && r >= h - 1) ? 0 : ((r + 1) & 32'hFFF);
    endfunction

    // row driver: bursts with random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_life_row(i_row_cells);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (rows_to_send.size() != 0) begin
                    i_in_valid  <= 1'b1;
                    i_row_cells <= rows_to_send.pop_front();
                    burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 4) == 0) begin
                            burst_left = $urandom_range(20, 40);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(0, 8);
                        end
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern
    int unsigned stall_left = 0;
    int unsigned free_left = 0;

    always @(posedge i_clk) begin
        t_life_row e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (next_gen_rows.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: row %0d cells %h last %0b",
                                 o_row_index, o_next_cells, o_last_of_run);
                end else begin
                    e = next_gen_rows.pop_front();
                    if (o_row_index !== e.row_index || o_next_cells !== e.cells ||
                        o_last_of_run !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected row %0d cells %h last %0b, got row %0d cells %h last %0b",
                                     e.row_index, e.cells, e.last,
                                     o_row_index, o_next_cells, o_last_of_run);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (free_left != 0) begin
                free_left--;
                i_out_stall <= 1'b0;
            end else begin
                free_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 6);
                stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15)
                                                         : $urandom_range(1, 3);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge i_clk);
        $display("toroidal_life_generation_tb failed");
        $finish;
    end

    // everything sent and answered, plus time for rows that give no result
    task automatic wait_idle();
        while (rows_to_send.size() != 0 || i_in_valid || next_gen_rows.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_GRID_WIDTH) cfg_width = val[WIDTH_CFG_W-1:0];
        else if (idx == CFG_GRID_HEIGHT) cfg_height = val[HEIGHT_CFG_W-1:0];
    endtask

    task automatic setup_grid(input logic [CFG_DATA_W-1:0] w_val,
                              input logic [CFG_DATA_W-1:0] h_val);
        wait_idle();
        write_reg(CFG_GRID_WIDTH, w_val);
        write_reg(CFG_GRID_HEIGHT, h_val);
    endtask

    function automatic logic [MAX_WIDTH-1:0] make_row();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return '1;
            2, 3:    return {$urandom, $urandom} & {$urandom, $urandom};
            4:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            5, 6:    return {$urandom, $urandom} | {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int unsigned           sent_random;
        int unsigned           n;
        int unsigned           h;
        int unsigned           pick;
        logic [CFG_DATA_W-1:0] w_val;
        logic [CFG_DATA_W-1:0] h_val;
        int unsigned           drain;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full width, three-row torus: solid, empty, striped and end-cell rows
        setup_grid(13'd64, 13'd3);
        rows_to_send.push_back('1);
        rows_to_send.push_back('0);
        rows_to_send.push_back({32{2'b10}});
        rows_to_send.push_back({32{2'b01}});
        rows_to_send.push_back(64'h8000_0000_0000_0001);
        rows_to_send.push_back('1);

        // single column: west and east both wrap onto the cell itself
        setup_grid(13'd1, 13'd3);
        repeat (3) rows_to_send.push_back({$urandom, $urandom});

        // two columns, height below minimum clamps to three
        setup_grid(13'd2, 13'd0);
        rows_to_send.push_back('1);
        repeat (2) rows_to_send.push_back({$urandom, $urandom});

        // width zero is taken as one
        setup_grid(13'd0, 13'd3);
        repeat (3) rows_to_send.push_back({$urandom, $urandom});

        // oversized width and height clamp; then height cut mid-generation
        setup_grid(13'h1FE4, 13'h1FFF);
        repeat (5) rows_to_send.push_back({$urandom, $urandom} | {$urandom, $urandom});
        wait_idle();
        write_reg(CFG_SPARE, 13'h0005);
        write_reg(CFG_GRID_HEIGHT, 13'd4);
        rows_to_send.push_back({$urandom, $urandom});

        sent_random = 0;
        while (sent_random < RANDOM_ROWS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) w_val = 13'd0;
            else if (pick == 1) w_val = CFG_DATA_W'($urandom_range(65, 8191));
            else if (pick < 4) w_val = CFG_DATA_W'($urandom_range(1, 2));
            else if (pick < 7) w_val = 13'd64;
            else w_val = CFG_DATA_W'($urandom_range(3, 63));
            pick = $urandom_range(0, 19);
            if (pick == 0) h_val = CFG_DATA_W'($urandom_range(0, 2));
            else if (pick == 1) h_val = CFG_DATA_W'($urandom_range(4097, 8191));
            else if (pick == 2) h_val = CFG_DATA_W'($urandom_range(25, 4096));
            else h_val = CFG_DATA_W'($urandom_range(3, 12));

            wait_idle();
            if ($urandom_range(0, 4) != 0) write_reg(CFG_GRID_WIDTH, w_val);
            if ($urandom_range(0, 4) != 0) write_reg(CFG_GRID_HEIGHT, h_val);
            if ($urandom_range(0, 15) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));

            h = active_height();
            if (h <= 24) begin
                n = h * $urandom_range(1, 3);
                // sometimes stop partway so the next setting meets a half-done generation
                if ($urandom_range(0, 5) == 0) n += $urandom_range(1, h - 1);
            end else begin
                n = $urandom_range(3, 24);
            end
            repeat (n) rows_to_send.push_back(make_row());
            sent_random += n;
        end

        drain = 0;
        while ((rows_to_send.size() != 0 || i_in_valid || next_gen_rows.size() != 0) &&
               drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES + 2) @(posedge i_clk);
        mismatches += next_gen_rows.size();

        if (mismatches == 0) begin
            $display("toroidal_life_generation_tb passed");
        end else begin
            $display("toroidal_life_generation_tb failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tlg_pkg.sv
rtl/tlg_front.sv
rtl/tlg_queue.sv
rtl/tlg_back.sv
rtl/toroidal_life_generation.sv
tb/sv/toroidal_life_generation_tb.sv
